// ===== sv/ppu_pkg.sv =====
// Shared types, codes and helpers for the packed pattern unpacker.
// No dependencies; imported by packed_pattern_unpacker.
package ppu_pkg;

  // cell slot codes, plus the marker for "next byte is a flag byte"
  localparam logic [2:0] SLOT_NOTE  = 3'd0;
  localparam logic [2:0] SLOT_INSTR = 3'd1;
  localparam logic [2:0] SLOT_VOL   = 3'd2;
  localparam logic [2:0] SLOT_CMD   = 3'd3;
  localparam logic [2:0] SLOT_ARG   = 3'd4;
  localparam logic [2:0] SLOT_FLAG  = 3'd7;

  // pending field bits taken from the flag byte
  localparam int PEND_NOTE = 0;
  localparam int PEND_VOL  = 1;
  localparam int PEND_CMD  = 2;

  // event kinds
  localparam logic [1:0] EV_CELL  = 2'd0;
  localparam logic [1:0] EV_ROW   = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;
  localparam logic [1:0] EV_ABORT = 2'd3;

  localparam logic [5:0] CHANNEL_COUNT_RESET = 6'd32;

  // row byte counter: covers channel_count*10 plus one flag group, saturating
  localparam int CNT_W = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [4:0] chan;
    logic [2:0] slot;
    logic [7:0] value;
  } event_t;

  // slot expected after slot 'done' has been consumed
  function automatic logic [2:0] next_slot(input logic [2:0] done, input logic [2:0] pend);
    logic [2:0] nxt;
    nxt = SLOT_FLAG;
    if (done == SLOT_FLAG && pend[PEND_NOTE])
      nxt = SLOT_NOTE;
    else if (done == SLOT_NOTE)
      nxt = SLOT_INSTR;
    else if ((done == SLOT_FLAG || done == SLOT_INSTR) && pend[PEND_VOL])
      nxt = SLOT_VOL;
    else if ((done == SLOT_FLAG || done == SLOT_INSTR || done == SLOT_VOL) && pend[PEND_CMD])
      nxt = SLOT_CMD;
    else if (done == SLOT_CMD)
      nxt = SLOT_ARG;
    return nxt;
  endfunction

endpackage

// ===== sv/packed_pattern_unpacker.sv =====
// Packed pattern unpacker: parser state, one-pass decode and output skid stage.
// Depends on ppu_pkg.
// A result goes into the result register, or into the skid register while the result register is held.
// One word per cycle while in_ready is high; parser state updates in one pass from the input.
// A two-entry output (result register plus skid register) keeps in_ready high
// while one result waits. rst (synchronous) clears the parser, the output
// valids and sets channel_count to 32.
module packed_pattern_unpacker #(
  parameter int ROWS_PER_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [5:0] row_index,
  output logic [4:0] channel_index,
  output logic [2:0] cell_slot,
  output logic [7:0] cell_value
);
  import ppu_pkg::*;

  localparam int RW = (ROWS_PER_PATTERN > 1) ? $clog2(ROWS_PER_PATTERN) : 1;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS_PER_PATTERN - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [5:0]       channel_count;
  logic [2:0]       expected_slot, expected_slot_next;
  logic [2:0]       pending, pending_next;
  logic [4:0]       current_channel, current_channel_next;
  logic             skipping, skipping_next;
  logic [RW-1:0]    row_counter, row_counter_next;
  logic [CNT_W-1:0] row_bytes, row_bytes_next;
  logic             finished, finished_next;

  // state after an optional parser reset by first_byte
  logic [2:0]       e_slot, e_pend;
  logic [4:0]       e_chan;
  logic             e_skip, e_fin;
  logic [RW-1:0]    e_row;
  logic [CNT_W-1:0] e_bytes, bytes_inc;
  logic [CNT_W-1:0] limit;
  logic [8:0]       row_wide;

  logic   in_fire, res_valid, res_fire;
  event_t res, out_ev, skid_ev;
  logic   skid_valid;

  assign in_fire  = in_valid && in_ready;
  assign res_fire = in_fire && res_valid;
  assign in_ready = !skid_valid;

  // channel_count * 10 as shifts
  assign limit = {1'b0, channel_count, 3'b000} + {3'b000, channel_count, 1'b0};

  always_comb begin
    if (first_byte) begin
      e_slot  = SLOT_FLAG;
      e_pend  = '0;
      e_chan  = '0;
      e_skip  = 1'b0;
      e_row   = '0;
      e_bytes = '0;
      e_fin   = 1'b0;
    end else begin
      e_slot  = expected_slot;
      e_pend  = pending;
      e_chan  = current_channel;
      e_skip  = skipping;
      e_row   = row_counter;
      e_bytes = row_bytes;
      e_fin   = finished;
    end
    bytes_inc = (e_bytes == CNT_MAX) ? e_bytes : e_bytes + 1'b1;
    row_wide  = 9'(e_row);

    expected_slot_next   = e_slot;
    pending_next         = e_pend;
    current_channel_next = e_chan;
    skipping_next        = e_skip;
    row_counter_next     = e_row;
    row_bytes_next       = e_bytes;
    finished_next        = e_fin;

    res_valid = 1'b0;
    res.kind  = EV_CELL;
    res.row   = row_wide[5:0];
    res.chan  = '0;
    res.slot  = '0;
    res.value = '0;

    if (!e_fin) begin
      row_bytes_next = bytes_inc;
      if (e_slot != SLOT_FLAG) begin
        expected_slot_next = next_slot(e_slot, e_pend);
        if (!e_skip) begin
          res_valid = 1'b1;
          res.chan  = e_chan;
          res.slot  = e_slot;
          res.value = data_byte;
        end
      end else if (bytes_inc > limit) begin
        finished_next = 1'b1;
        res_valid     = 1'b1;
        res.kind      = EV_ABORT;
      end else if (data_byte == 8'd0) begin
        row_bytes_next = '0;
        res_valid      = 1'b1;
        if (e_row == LAST_ROW) begin
          finished_next = 1'b1;
          res.kind      = EV_DONE;
        end else begin
          res.kind         = EV_ROW;
          row_counter_next = e_row + 1'b1;
        end
      end else begin
        current_channel_next = data_byte[4:0];
        skipping_next        = {1'b0, data_byte[4:0]} > channel_count;
        pending_next         = data_byte[7:5];
        expected_slot_next   = next_slot(SLOT_FLAG, data_byte[7:5]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RESET;
    end else if (cfg_wr_en) begin
      channel_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_slot   <= SLOT_FLAG;
      pending         <= '0;
      current_channel <= '0;
      skipping        <= 1'b0;
      row_counter     <= '0;
      row_bytes       <= '0;
      finished        <= 1'b0;
    end else if (in_fire) begin
      expected_slot   <= expected_slot_next;
      pending         <= pending_next;
      current_channel <= current_channel_next;
      skipping        <= skipping_next;
      row_counter     <= row_counter_next;
      row_bytes       <= row_bytes_next;
      finished        <= finished_next;
    end
  end

  // result register with a skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_ev     <= skid_ev;
        skid_valid <= 1'b0;
      end else if (res_fire) begin
        out_ev <= res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (res_fire) begin
      if (out_valid) begin
        skid_ev    <= res;
        skid_valid <= 1'b1;
      end else begin
        out_ev    <= res;
        out_valid <= 1'b1;
      end
    end
  end

  assign event_kind    = out_ev.kind;
  assign row_index     = out_ev.row;
  assign channel_index = out_ev.chan;
  assign cell_slot     = out_ev.slot;
  assign cell_value    = out_ev.value;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty result register");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_counter <= LAST_ROW)
    else $error("row counter past last row");

  a_finished_holds: assert property (@(posedge clk) disable iff (rst)
    (in_fire && finished && !first_byte) |=> (finished && $stable(row_counter)))
    else $error("finished pattern changed without a first word");

  a_slot_code: assert property (@(posedge clk) disable iff (rst)
    expected_slot <= SLOT_ARG || expected_slot == SLOT_FLAG)
    else $error("expected slot holds an unused code");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for packed_pattern_unpacker: random and directed pattern words,
// with a local predictor of row, cell, done and abort events.
// Depends on ppu_pkg and packed_pattern_unpacker.
module tb_top;
  import ppu_pkg::*;

  localparam int PATTERN_ROWS = 64;
  localparam int PHASE_WORDS  = 170;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } word_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic       first_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] event_kind;
  logic [5:0] row_index;
  logic [4:0] channel_index;
  logic [2:0] cell_slot;
  logic [7:0] cell_value;

  packed_pattern_unpacker #(.ROWS_PER_PATTERN(PATTERN_ROWS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .first_byte(first_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .row_index(row_index),
    .channel_index(channel_index),
    .cell_slot(cell_slot),
    .cell_value(cell_value)
  );

  word_t      words_to_send[$];
  event_t     events_due[$];
  int         words_queued;
  int         mismatches;

  // predictor state
  logic [5:0] chan_limit;
  logic [2:0] slots_ahead[$];
  logic [4:0] cur_chan;
  bit         chan_skipped;
  bit         pat_over;
  int         row_num;
  int         row_bytes;

  // handshake bookkeeping
  bit         in_fire;
  int         in_gap;
  bit         in_calm;
  int         in_calm_left;
  int         stall_left;
  bit         out_calm;
  int         out_calm_left;
  event_t     want_ev;
  word_t      next_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser();
    slots_ahead.delete();
    cur_chan     = '0;
    chan_skipped = 1'b0;
    pat_over     = 1'b0;
    row_num      = 0;
    row_bytes    = 0;
  endfunction

  // works out the event (if any) that one accepted word causes
  task automatic unpack_word(input logic [7:0] b, input logic first);
    event_t ev;
    ev = '0;
    if (first) clear_parser();
    if (pat_over) return;
    row_bytes++;
    ev.row = row_num[5:0];
    if (slots_ahead.size() != 0) begin
      ev.slot = slots_ahead.pop_front();
      if (!chan_skipped) begin
        ev.kind  = EV_CELL;
        ev.chan  = cur_chan;
        ev.value = b;
        events_due.push_back(ev);
      end
      return;
    end
    // row length only checked on flag and zero words
    if (row_bytes > 10 * chan_limit) begin
      pat_over = 1'b1;
      ev.kind  = EV_ABORT;
      events_due.push_back(ev);
      return;
    end
    if (b == 8'h00) begin
      row_bytes = 0;
      if (row_num == PATTERN_ROWS - 1) begin
        pat_over = 1'b1;
        ev.kind  = EV_DONE;
      end else begin
        ev.kind = EV_ROW;
        row_num++;
      end
      events_due.push_back(ev);
      return;
    end
    cur_chan     = b[4:0];
    chan_skipped = b[4:0] > chan_limit;
    if (b[5]) begin
      slots_ahead.push_back(SLOT_NOTE);
      slots_ahead.push_back(SLOT_INSTR);
    end
    if (b[6]) slots_ahead.push_back(SLOT_VOL);
    if (b[7]) begin
      slots_ahead.push_back(SLOT_CMD);
      slots_ahead.push_back(SLOT_ARG);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_word(input logic [7:0] d, input logic f);
    word_t w;
    w.data  = d;
    w.first = f;
    words_to_send.push_back(w);
    words_queued++;
  endtask

  // one pattern: mostly well-formed rows, some over-long ones, a little noise
  task automatic add_pattern(input int cc);
    int         rows;
    int         target;
    int         left;
    int         lim;
    logic [2:0] mask;
    logic [4:0] chan;
    bit         lead;
    lim  = 10 * cc;
    rows = ($urandom_range(0, 4) == 0) ? $urandom_range(1, PATTERN_ROWS - 1) : PATTERN_ROWS;
    lead = 1'b1;
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(0, 9) < 3) target = 1;
      else target = $urandom_range(2, 12);
      // right at the limit, or one word past it
      if ($urandom_range(0, 999) < ((lim <= 60) ? 40 : 5)) target = lim + $urandom_range(0, 1);
      if (target < 1) target = 1;
      left = target - 1;
      while (left > 0) begin
        mask = 3'($urandom_range(0, 7));
        while (1 + 2 * mask[0] + mask[1] + 2 * mask[2] > left) mask = mask - 3'd1;
        if ($urandom_range(0, 4) == 0) chan = 5'($urandom_range(0, 31));
        else chan = 5'($urandom_range(0, (cc > 31) ? 31 : cc));
        if (mask == 3'd0 && chan == 5'd0) chan = 5'd1;
        push_word({mask, chan}, lead);
        lead = 1'b0;
        repeat (2 * mask[0] + mask[1] + 2 * mask[2])
          push_word(8'($urandom_range(0, 255)), 1'b0);
        left -= 1 + 2 * mask[0] + mask[1] + 2 * mask[2];
      end
      push_word(8'h00, lead);
      lead = 1'b0;
      if (target > lim) break;
      if ($urandom_range(0, 99) < 3)
        push_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
    repeat ($urandom_range(0, 2)) push_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic wait_idle();
    while (words_to_send.size() != 0 || in_valid || events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // input side: words leave at the falling edge
  always @(negedge clk) begin
    if (in_calm_left == 0) begin
      in_calm      = $urandom_range(0, 3) == 0;
      in_calm_left = $urandom_range(20, 300);
    end else begin
      in_calm_left--;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_fire) in_gap = pick_gap(in_calm);
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (words_to_send.size() != 0) begin
        next_word = words_to_send.pop_front();
        in_valid   <= 1'b1;
        data_byte  <= next_word.data;
        first_byte <= next_word.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side back-pressure
  always @(negedge clk) begin
    if (out_calm_left == 0) begin
      out_calm      = $urandom_range(0, 3) == 0;
      out_calm_left = $urandom_range(20, 300);
    end else begin
      out_calm_left--;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap(out_calm);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) unpack_word(data_byte, first_byte);
      if (out_valid && out_ready) begin
        if (events_due.size() == 0) begin
          $display("%0t: event with none expected, kind %0d row %0d chan %0d slot %0d value %0d",
                   $time, event_kind, row_index, channel_index, cell_slot, cell_value);
          mismatches++;
        end else begin
          want_ev = events_due.pop_front();
          check_field("event_kind", 8'(want_ev.kind), 8'(event_kind));
          check_field("row_index", 8'(want_ev.row), 8'(row_index));
          check_field("channel_index", 8'(want_ev.chan), 8'(channel_index));
          check_field("cell_slot", 8'(want_ev.slot), 8'(cell_slot));
          check_field("cell_value", want_ev.value, cell_value);
        end
      end
    end
  end

  initial begin
    int plan[5];
    int cc;
    int stop_at;
    plan = '{1, 0, 32, 31, 2};
    chan_limit = CHANNEL_COUNT_RESET;
    clear_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset channel count: all fields, each field alone and none, full-range data
    push_word(8'hFF, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'h7F, 1'b0);
    push_word(8'h25, 1'b0);
    push_word(8'hAA, 1'b0);
    push_word(8'h55, 1'b0);
    push_word(8'h40, 1'b0);
    push_word(8'h10, 1'b0);
    push_word(8'h81, 1'b0);
    push_word(8'h0F, 1'b0);
    push_word(8'hF0, 1'b0);
    push_word(8'h1F, 1'b0);
    push_word(8'h00, 1'b0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      cc = (p < 5) ? plan[p] : $urandom_range(0, 32);
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= cc[5:0];
      chan_limit   = cc[5:0];
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      case (p)
        0: begin
          // channel above the count is skipped, channel equal to it is kept
          push_word(8'h22, 1'b1);
          push_word(8'h3C, 1'b0);
          push_word(8'hC3, 1'b0);
          push_word(8'h61, 1'b0);
          push_word(8'h30, 1'b0);
          push_word(8'h07, 1'b0);
          push_word(8'h99, 1'b0);
          push_word(8'h00, 1'b0);
        end
        1: begin
          // zero channels: first word aborts, the rest is ignored
          push_word(8'h00, 1'b1);
          push_word(8'h41, 1'b0);
        end
        default: ;
      endcase
      stop_at = words_queued + PHASE_WORDS;
      while (words_queued < stop_at) add_pattern(cc);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ppu_pkg.sv
sv/packed_pattern_unpacker.sv
verif/tb_top.sv
